### hdl/mprc_pkg.sv
// ----------------------------------------------------------------------------
// mprc_pkg
// Shared types, constants and helpers of the multiset permutation rank codec.
// ----------------------------------------------------------------------------
package mprc_pkg;

  localparam int MAX_DIM    = 32;
  localparam int MAX_VALUES = 4;
  localparam int VALUE_BITS = 16;
  localparam int CODE_W     = 64;
  localparam int DIM_W      = 6;
  localparam int CNT_W      = 6;
  localparam int VLEN_W     = 6;
  localparam int VCNT_W     = 3;
  localparam int CTAB_W     = 24;
  localparam int POS_W      = $clog2(MAX_DIM);
  localparam int VSEL_W     = $clog2(MAX_VALUES);
  localparam int JW         = $clog2(MAX_VALUES + 1);
  localparam int BIN_ROWS   = MAX_DIM + 1;
  localparam int BIN_DEPTH  = BIN_ROWS * BIN_ROWS;
  localparam int BIN_AW     = $clog2(BIN_DEPTH);
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VECTOR_LENGTH,
    REG_VALUE_COUNT,
    REG_VALUE_TABLE,
    REG_COUNT_TABLE
  } cfg_reg_t;

  typedef struct packed {
    logic [VLEN_W-1:0] vector_length;
    logic [VCNT_W-1:0] value_count;
    logic [CODE_W-1:0] value_table;
    logic [CTAB_W-1:0] count_table;
  } cfg_t;

  typedef struct packed {
    logic                         op;
    logic signed [VALUE_BITS-1:0] element_value;
    logic                         element_last;
    logic [CODE_W-1:0]            code_in;
  } in_t;

  typedef struct packed {
    logic                         result_kind;
    logic [CODE_W-1:0]            code_out;
    logic signed [VALUE_BITS-1:0] value_out;
    logic [POS_W-1:0]             position;
    logic                         last;
    logic                         mismatch;
  } out_t;

  typedef struct packed {
    logic              is_dec;
    logic [CODE_W-1:0] code;
    logic              mis;
  } cmd_t;

  typedef struct packed {
    logic                  we;
    logic [POS_W-1:0]      addr;
    logic [VALUE_BITS-1:0] data;
  } st_wr_t;

  typedef struct packed {
    logic              we;
    logic [BIN_AW-1:0] addr;
    logic [CODE_W-1:0] data;
  } bin_wr_t;

  typedef enum logic [4:0] {
    S_P_RD, S_P_WR, S_IDLE, S_VAL,
    S_E_RD, S_E_CMP, S_E_ADD, S_E_END, S_E_BRD, S_E_BLD, S_E_FIN,
    S_M0, S_M1, S_M2, S_M3,
    S_D_DIV0, S_D_DIV, S_SD_RD, S_SD_CMP, S_D_SCAN, S_D_NEXT, S_D_FIN,
    S_OUT
  } bstate_t;

  function automatic logic [DIM_W-1:0] get_dim(input cfg_t c);
    return (c.vector_length > VLEN_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : c.vector_length;
  endfunction

  function automatic logic [JW-1:0] get_nvals(input cfg_t c);
    return (c.value_count > VCNT_W'(MAX_VALUES)) ? JW'(MAX_VALUES) : JW'(c.value_count);
  endfunction

  function automatic logic [VALUE_BITS-1:0] tbl_value(input cfg_t c,
                                                      input logic [VSEL_W-1:0] j);
    return c.value_table[j*VALUE_BITS +: VALUE_BITS];
  endfunction

  function automatic logic [CNT_W-1:0] tbl_count(input cfg_t c,
                                                 input logic [VSEL_W-1:0] j);
    return c.count_table[j*CNT_W +: CNT_W];
  endfunction

  function automatic logic bin_oob(input logic [DIM_W-1:0] n,
                                   input logic [CNT_W-1:0] k);
    return (n > DIM_W'(MAX_DIM)) || (k > CNT_W'(MAX_DIM));
  endfunction

  function automatic logic [BIN_AW-1:0] bin_addr(input logic [DIM_W-1:0] n,
                                                 input logic [CNT_W-1:0] k);
    return BIN_AW'(n) * BIN_AW'(BIN_ROWS) + BIN_AW'(k);
  endfunction

  function automatic logic [MAX_DIM-1:0] full_mask(input logic [DIM_W-1:0] dim);
    logic [MAX_DIM-1:0] m;
    for (int i = 0; i < MAX_DIM; i++) begin
      m[i] = (DIM_W'(i) < dim);
    end
    return m;
  endfunction

endpackage

### hdl/mprc_ram.sv
// ----------------------------------------------------------------------------
// mprc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mprc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/mprc_front.sv
// ----------------------------------------------------------------------------
// mprc_front
// Input side: config registers, element loading and the command queue.
// ----------------------------------------------------------------------------
module mprc_front import mprc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CODE_W-1:0]    cfg_wdata,
  output cfg_t                 cfg,
  output st_wr_t               st_wr,
  output logic                 cmd_valid,
  output cmd_t                 cmd,
  input  logic                 cmd_pop,
  input  logic                 back_busy
);

  cfg_t             cfg_r, cfg_nxt;
  logic [DIM_W-1:0] lidx_r, lidx_nxt;
  logic             lmis_r, lmis_nxt;
  cmd_t             q0_r, q0_nxt, q1_r, q1_nxt;
  logic [1:0]       qcnt_r, qcnt_nxt;

  logic             acc, load, wr_ok, push, pop, lmis_new;
  logic [DIM_W-1:0] dim, lidx_inc;
  cmd_t             new_cmd;

  assign dim = get_dim(cfg_r);

  // loads wait until the back end has finished with the store
  assign in_stall = in_data.op ? (qcnt_r == 2'd2) : ((qcnt_r != 2'd0) || back_busy);
  assign acc      = in_valid && !in_stall;
  assign load     = acc && !in_data.op;
  assign wr_ok    = lidx_r < dim;
  assign lidx_inc = (lidx_r == {DIM_W{1'b1}}) ? lidx_r : lidx_r + DIM_W'(1);
  assign lmis_new = lmis_r || (load && !wr_ok);
  assign push     = acc && (in_data.op || in_data.element_last);
  assign pop      = cmd_pop && (qcnt_r != 2'd0);

  assign st_wr.we   = load && wr_ok;
  assign st_wr.addr = lidx_r[POS_W-1:0];
  assign st_wr.data = in_data.element_value;

  always_comb begin
    new_cmd.is_dec = in_data.op;
    new_cmd.code   = in_data.code_in;
    new_cmd.mis    = !in_data.op && (lmis_new || (lidx_inc != dim));
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_VECTOR_LENGTH: cfg_nxt.vector_length = cfg_wdata[VLEN_W-1:0];
        REG_VALUE_COUNT:   cfg_nxt.value_count   = cfg_wdata[VCNT_W-1:0];
        REG_VALUE_TABLE:   cfg_nxt.value_table   = cfg_wdata;
        REG_COUNT_TABLE:   cfg_nxt.count_table   = cfg_wdata[CTAB_W-1:0];
      endcase
    end
  end

  always_comb begin
    lidx_nxt = lidx_r;
    lmis_nxt = lmis_r;
    if (load) begin
      lidx_nxt = in_data.element_last ? '0 : lidx_inc;
      lmis_nxt = in_data.element_last ? 1'b0 : lmis_new;
    end
  end

  always_comb begin
    q0_nxt   = q0_r;
    q1_nxt   = q1_r;
    qcnt_nxt = qcnt_r;
    priority if (push && pop) begin
      if (qcnt_r == 2'd1) begin
        q0_nxt = new_cmd;
      end else begin
        q0_nxt = q1_r;
        q1_nxt = new_cmd;
      end
    end else if (push) begin
      if (qcnt_r == 2'd0) begin
        q0_nxt = new_cmd;
      end else begin
        q1_nxt = new_cmd;
      end
      qcnt_nxt = qcnt_r + 2'd1;
    end else if (pop) begin
      q0_nxt   = q1_r;
      qcnt_nxt = qcnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.vector_length <= VLEN_W'(MAX_DIM);
      cfg_r.value_count   <= VCNT_W'(1);
      cfg_r.value_table   <= '0;
      cfg_r.count_table   <= CTAB_W'(MAX_DIM);
      lidx_r              <= '0;
      lmis_r              <= 1'b0;
      qcnt_r              <= '0;
    end else begin
      cfg_r  <= cfg_nxt;
      lidx_r <= lidx_nxt;
      lmis_r <= lmis_nxt;
      qcnt_r <= qcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  assign cfg       = cfg_r;
  assign cmd_valid = (qcnt_r != 2'd0);
  assign cmd       = q0_r;

endmodule

### hdl/mprc_back.sv
// ----------------------------------------------------------------------------
// mprc_back
// Execution side: Pascal table fill, encode ranking, decode unranking.
// ----------------------------------------------------------------------------
module mprc_back import mprc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  cmd_valid,
  input  cmd_t                  cmd,
  output logic                  cmd_pop,
  output logic                  busy,
  output logic [POS_W-1:0]      st_raddr,
  input  logic [VALUE_BITS-1:0] st_rdata,
  output bin_wr_t               bin_wr,
  output logic [BIN_AW-1:0]     bin_raddr,
  input  logic [CODE_W-1:0]     bin_rdata,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data
);

  bstate_t state_r, state_nxt;

  logic [DIM_W-1:0]  pn_r, pn_nxt;
  logic [CNT_W-1:0]  pk_r, pk_nxt;
  logic [CODE_W-1:0] held_r, held_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r, out_nxt;

  logic              is_dec_r, is_dec_nxt;
  logic [JW-1:0]     j_r, j_nxt;
  logic [DIM_W-1:0]  nfree_r, nfree_nxt;
  logic [CODE_W-1:0] code_r, code_nxt, radix_r, radix_nxt, cc_r, cc_nxt;
  logic              mis_r, mis_nxt;
  logic [MAX_DIM-1:0] mask_r, mask_nxt;
  logic [VSEL_W-1:0] vsel_r [MAX_DIM];
  logic [VSEL_W-1:0] vsel_nxt [MAX_DIM];
  logic [DIM_W-1:0]  i_r, i_nxt;
  logic [DIM_W:0]    rank_r, rank_nxt;
  logic [CNT_W-1:0]  occ_r, occ_nxt, sdk_r, sdk_nxt;
  logic [DIM_W-1:0]  sdr_r, sdr_nxt;
  logic [CODE_W-1:0] ma_r, ma_nxt, mb_r, mb_nxt, p_r, p_nxt, dv_r, dv_nxt;
  logic [31:0]       t_r, t_nxt, t2_r, t2_nxt;
  logic              msel_r, msel_nxt;
  logic [5:0]        dcnt_r, dcnt_nxt;
  logic              bin_oob_r;

  logic [DIM_W-1:0]  dim, bin_n, i_m1;
  logic [CNT_W-1:0]  bin_k, cnt, occ_p1;
  logic [JW-1:0]     nvals;
  logic [VSEL_W-1:0] cur_j;
  logic [VALUE_BITS-1:0] cur_val;
  logic [CODE_W-1:0] bin_q, mul_res;
  logic [31:0]       mop_a, mop_b;
  logic [63:0]       prod;
  logic [CODE_W:0]   dsh, ddiff;
  logic              out_free, match, hit;
  logic [POS_W-1:0]  idx;

  assign dim      = get_dim(cfg);
  assign nvals    = get_nvals(cfg);
  assign cur_j    = j_r[VSEL_W-1:0];
  assign cur_val  = tbl_value(cfg, cur_j);
  assign cnt      = tbl_count(cfg, cur_j);
  assign occ_p1   = occ_r + CNT_W'(1);
  assign i_m1     = i_r - DIM_W'(1);
  assign idx      = i_m1[POS_W-1:0];
  assign bin_q    = bin_oob_r ? '0 : bin_rdata;
  assign out_free = !out_valid_r || !out_stall;
  assign match    = (st_rdata == cur_val);
  assign hit      = ((rank_r - (DIM_W+1)'(1)) == {1'b0, sdr_r});
  assign st_raddr = i_r[POS_W-1:0];
  assign dsh      = {cc_r, code_r[CODE_W-1]};
  assign ddiff    = dsh - {1'b0, dv_r};

  // one 32x32 multiplier, three partial products per 64-bit product
  always_comb begin
    unique case (state_r)
      S_M1:    begin mop_a = ma_r[31:0];  mop_b = mb_r[63:32]; end
      S_M2:    begin mop_a = ma_r[63:32]; mop_b = mb_r[31:0];  end
      default: begin mop_a = ma_r[31:0];  mop_b = mb_r[31:0];  end
    endcase
  end
  assign prod    = {32'b0, mop_a} * {32'b0, mop_b};
  assign mul_res = p_r + {t_r + t2_r, 32'b0};

  // binomial table read address
  always_comb begin
    unique case (state_r)
      S_P_RD:         begin bin_n = pn_r - DIM_W'(1); bin_k = pk_r;    end
      S_E_CMP:        begin bin_n = rank_r[DIM_W-1:0]; bin_k = occ_p1; end
      S_E_BRD, S_VAL: begin bin_n = nfree_r;           bin_k = cnt;    end
      S_SD_RD:        begin bin_n = sdr_r;             bin_k = sdk_r;  end
      default:        begin bin_n = '0;                bin_k = '0;     end
    endcase
  end
  assign bin_raddr = bin_oob(bin_n, bin_k) ? '0 : bin_addr(bin_n, bin_k);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_P_RD: state_nxt = S_P_WR;
      S_P_WR: begin
        if ((pn_r == DIM_W'(MAX_DIM)) && (pk_r == CNT_W'(MAX_DIM))) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_P_RD;
        end
      end
      S_IDLE: if (cmd_valid) state_nxt = S_VAL;
      S_VAL: begin
        priority if (j_r == nvals) begin
          state_nxt = is_dec_r ? S_D_FIN : S_E_FIN;
        end else if (cnt == '0) begin
          state_nxt = S_VAL;
        end else if (is_dec_r) begin
          state_nxt = (cnt > CNT_W'(nfree_r)) ? S_VAL : S_D_DIV0;
        end else begin
          state_nxt = S_E_RD;
        end
      end
      S_E_RD: begin
        priority if (i_r == dim) state_nxt = S_E_END;
        else if (mask_r[i_r[POS_W-1:0]]) state_nxt = S_E_RD;
        else state_nxt = S_E_CMP;
      end
      S_E_CMP: state_nxt = match ? S_E_ADD : S_E_RD;
      S_E_ADD: state_nxt = (occ_p1 == cnt) ? S_E_END : S_E_RD;
      S_E_END: state_nxt = S_M0;
      S_E_BRD: state_nxt = S_E_BLD;
      S_E_BLD: state_nxt = S_M0;
      S_M0:    state_nxt = S_M1;
      S_M1:    state_nxt = S_M2;
      S_M2:    state_nxt = S_M3;
      S_M3:    state_nxt = msel_r ? S_VAL : S_E_BRD;
      S_E_FIN: state_nxt = S_OUT;
      S_D_DIV0: state_nxt = S_D_DIV;
      S_D_DIV: state_nxt = (dcnt_r == 6'd63) ? S_SD_RD : S_D_DIV;
      S_SD_RD: state_nxt = S_SD_CMP;
      S_SD_CMP: begin
        state_nxt = ((sdr_r != '0) && (bin_q > cc_r)) ? S_SD_RD : S_D_SCAN;
      end
      S_D_SCAN: begin
        priority if (i_r == '0) state_nxt = S_D_NEXT;
        else if (mask_r[idx]) state_nxt = S_D_SCAN;
        else if (hit) state_nxt = (occ_p1 == cnt) ? S_D_NEXT : S_SD_RD;
        else state_nxt = S_D_SCAN;
      end
      S_D_NEXT: state_nxt = S_VAL;
      S_D_FIN:  state_nxt = (dim == '0) ? S_IDLE : S_OUT;
      S_OUT: begin
        if (out_free && (!is_dec_r || (i_r + DIM_W'(1) == dim))) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pn_nxt = pn_r;  pk_nxt = pk_r;  held_nxt = held_r;
    is_dec_nxt = is_dec_r;  j_nxt = j_r;  nfree_nxt = nfree_r;
    code_nxt = code_r;  radix_nxt = radix_r;  cc_nxt = cc_r;  mis_nxt = mis_r;
    mask_nxt = mask_r;  vsel_nxt = vsel_r;  i_nxt = i_r;  rank_nxt = rank_r;
    occ_nxt = occ_r;  sdk_nxt = sdk_r;  sdr_nxt = sdr_r;
    ma_nxt = ma_r;  mb_nxt = mb_r;  p_nxt = p_r;  t_nxt = t_r;  t2_nxt = t2_r;
    dv_nxt = dv_r;  msel_nxt = msel_r;  dcnt_nxt = dcnt_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd_pop = 1'b0;
    bin_wr.we   = 1'b0;
    bin_wr.addr = bin_addr(pn_r, pk_r);
    bin_wr.data = (pn_r == '0) ? CODE_W'(pk_r == '0) : bin_q + held_r;
    unique case (state_r)
      S_P_WR: begin
        bin_wr.we = 1'b1;
        held_nxt  = bin_q;
        if (pk_r == CNT_W'(MAX_DIM)) begin
          pk_nxt   = '0;
          pn_nxt   = pn_r + DIM_W'(1);
          held_nxt = '0;
        end else begin
          pk_nxt = pk_r + CNT_W'(1);
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop    = 1'b1;
          is_dec_nxt = cmd.is_dec;
          code_nxt   = cmd.is_dec ? cmd.code : '0;
          radix_nxt  = CODE_W'(1);
          mis_nxt    = cmd.mis;
          mask_nxt   = '0;
          j_nxt      = '0;
          nfree_nxt  = dim;
        end
      end
      S_VAL: begin
        if (j_r != nvals) begin
          priority if (cnt == '0) begin
            j_nxt = j_r + JW'(1);
          end else if (is_dec_r) begin
            if (cnt > CNT_W'(nfree_r)) begin
              mis_nxt   = 1'b1;
              nfree_nxt = '0;
              j_nxt     = j_r + JW'(1);
            end
          end else begin
            i_nxt    = '0;
            rank_nxt = '0;
            occ_nxt  = '0;
            cc_nxt   = '0;
          end
        end
      end
      S_E_RD: begin
        if ((i_r != dim) && mask_r[i_r[POS_W-1:0]]) i_nxt = i_r + DIM_W'(1);
      end
      S_E_CMP: begin
        if (!match) begin
          rank_nxt = rank_r + (DIM_W+1)'(1);
          i_nxt    = i_r + DIM_W'(1);
        end
      end
      S_E_ADD: begin
        cc_nxt                      = cc_r + bin_q;
        occ_nxt                     = occ_p1;
        mask_nxt[i_r[POS_W-1:0]]    = 1'b1;
        rank_nxt                    = rank_r + (DIM_W+1)'(1);
        i_nxt                       = i_r + DIM_W'(1);
      end
      S_E_END: begin
        if (occ_r < cnt) mis_nxt = 1'b1;
        ma_nxt   = radix_r;
        mb_nxt   = cc_r;
        msel_nxt = 1'b0;
      end
      S_E_BLD: begin
        ma_nxt   = radix_r;
        mb_nxt   = bin_q;
        msel_nxt = 1'b1;
      end
      S_M0: p_nxt  = prod;
      S_M1: t_nxt  = prod[31:0];
      S_M2: t2_nxt = prod[31:0];
      S_M3: begin
        if (msel_r) begin
          radix_nxt = mul_res;
          if (cnt > CNT_W'(nfree_r)) begin
            mis_nxt   = 1'b1;
            nfree_nxt = '0;
          end else begin
            nfree_nxt = nfree_r - DIM_W'(cnt);
          end
          j_nxt = j_r + JW'(1);
        end else begin
          code_nxt = code_r + mul_res;
        end
      end
      S_E_FIN: begin
        if ((mask_r & full_mask(dim)) != full_mask(dim)) mis_nxt = 1'b1;
      end
      S_D_DIV0: begin
        dv_nxt   = bin_q;
        cc_nxt   = '0;
        dcnt_nxt = '0;
        sdr_nxt  = nfree_r;
        sdk_nxt  = cnt;
        i_nxt    = dim;
        rank_nxt = {1'b0, nfree_r};
        occ_nxt  = '0;
      end
      S_D_DIV: begin
        // restoring division, one quotient bit per cycle
        if (!ddiff[CODE_W]) begin
          cc_nxt   = ddiff[CODE_W-1:0];
          code_nxt = {code_r[CODE_W-2:0], 1'b1};
        end else begin
          cc_nxt   = dsh[CODE_W-1:0];
          code_nxt = {code_r[CODE_W-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 6'd1;
      end
      S_SD_CMP: begin
        if ((sdr_r != '0) && (bin_q > cc_r)) begin
          sdr_nxt = sdr_r - DIM_W'(1);
        end else if (bin_q <= cc_r) begin
          cc_nxt = cc_r - bin_q;
        end
      end
      S_D_SCAN: begin
        if (i_r != '0) begin
          i_nxt = i_m1;
          if (!mask_r[idx]) begin
            rank_nxt = rank_r - (DIM_W+1)'(1);
            if (hit) begin
              mask_nxt[idx] = 1'b1;
              vsel_nxt[idx] = cur_j;
              occ_nxt       = occ_p1;
              sdk_nxt       = cnt - occ_p1;
            end
          end
        end
      end
      S_D_NEXT: begin
        nfree_nxt = nfree_r - DIM_W'(cnt);
        j_nxt     = j_r + JW'(1);
      end
      S_D_FIN: begin
        if (nfree_r != '0) mis_nxt = 1'b1;
        i_nxt = '0;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt.result_kind  = is_dec_r;
          out_nxt.code_out     = is_dec_r ? '0 : code_r;
          out_nxt.value_out    = (is_dec_r && mask_r[i_r[POS_W-1:0]])
                                 ? tbl_value(cfg, vsel_r[i_r[POS_W-1:0]]) : '0;
          out_nxt.position     = is_dec_r ? i_r[POS_W-1:0] : '0;
          out_nxt.last         = !is_dec_r || (i_r + DIM_W'(1) == dim);
          out_nxt.mismatch     = mis_r;
          if (is_dec_r) i_nxt = i_r + DIM_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_P_RD;
      pn_r        <= '0;
      pk_r        <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pn_r        <= pn_nxt;
      pk_r        <= pk_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_oob_r <= bin_oob(bin_n, bin_k);
    is_dec_r  <= is_dec_nxt;
    j_r       <= j_nxt;
    nfree_r   <= nfree_nxt;
    code_r    <= code_nxt;
    radix_r   <= radix_nxt;
    cc_r      <= cc_nxt;
    mis_r     <= mis_nxt;
    mask_r    <= mask_nxt;
    vsel_r    <= vsel_nxt;
    i_r       <= i_nxt;
    rank_r    <= rank_nxt;
    occ_r     <= occ_nxt;
    sdk_r     <= sdk_nxt;
    sdr_r     <= sdr_nxt;
    ma_r      <= ma_nxt;
    mb_r      <= mb_nxt;
    p_r       <= p_nxt;
    t_r       <= t_nxt;
    t2_r      <= t2_nxt;
    dv_r      <= dv_nxt;
    msel_r    <= msel_nxt;
    dcnt_r    <= dcnt_nxt;
    out_r     <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### hdl/multiset_permutation_rank_codec.sv
// ----------------------------------------------------------------------------
// multiset_permutation_rank_codec
// Ranks and unranks vectors drawn from a configured multiset of values.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_stall/in_data): op 0 loads one element at the
//   next position; element_last closes the vector and starts the encode,
//   which returns one result with the 64-bit code. op 1 decodes code_in and
//   returns min(vector_length, 32) results, one element per position, in order.
//   cfg port: write vector_length, value_count, value_table, count_table
//   by index while the block is idle.
//   Loads are taken one per cycle while no command is in flight; decodes queue
//   up to two deep. Encode scans the stored positions for each value and forms
//   two 64-bit products per value on the shared 32x32 multiplier. Decode runs
//   the bit-serial divider for each value, then binomial steps and a scan of
//   the positions, then emits one element per cycle while out_stall is low.
//   After reset the back end fills the 33x33 binomial table in RAM, reading
//   and writing each entry in turn; loads are held off meanwhile.
//   A stalled out channel holds its result; the back end waits on it.
// ----------------------------------------------------------------------------
module multiset_permutation_rank_codec import mprc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CODE_W-1:0]    cfg_wdata
);

  cfg_t                  cfg;
  st_wr_t                st_wr;
  bin_wr_t               bin_wr;
  cmd_t                  cmd;
  logic                  cmd_valid, cmd_pop, back_busy;
  logic [POS_W-1:0]      st_raddr;
  logic [VALUE_BITS-1:0] st_rdata;
  logic [BIN_AW-1:0]     bin_raddr;
  logic [CODE_W-1:0]     bin_rdata;

  mprc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .st_wr     (st_wr),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .back_busy (back_busy)
  );

  mprc_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_DIM)) u_store (
    .clk   (clk),
    .we    (st_wr.we),
    .waddr (st_wr.addr),
    .wdata (st_wr.data),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  mprc_ram #(.WIDTH(CODE_W), .DEPTH(BIN_DEPTH)) u_binom (
    .clk   (clk),
    .we    (bin_wr.we),
    .waddr (bin_wr.addr),
    .wdata (bin_wr.data),
    .raddr (bin_raddr),
    .rdata (bin_rdata)
  );

  mprc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .busy      (back_busy),
    .st_raddr  (st_raddr),
    .st_rdata  (st_rdata),
    .bin_wr    (bin_wr),
    .bin_raddr (bin_raddr),
    .bin_rdata (bin_rdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### hdl/mprc_check.sv
// ----------------------------------------------------------------------------
// mprc_check
// Port-level assertions for the rank codec, bound to the top level.
// ----------------------------------------------------------------------------
module mprc_check import mprc_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input in_t                  in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input out_t                 out_data,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [CODE_W-1:0]    cfg_wdata
);

  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // an encode result is a single, final transfer with empty element fields
  a_enc_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.result_kind |->
      out_data.last && (out_data.position == '0) && (out_data.value_out == '0))
    else $error("malformed encode result");

  a_dec_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind |-> (out_data.code_out == '0))
    else $error("decode result carries a code");

endmodule

bind multiset_permutation_rank_codec mprc_check u_check (.*);
